FILE: hdl/ppp_pkg.sv
// Shared constants and types for the perspective point projection core.
package ppp_pkg;

   localparam int DATA_W   = 32;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X_AB = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X_CD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y_AB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y_CD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_W_AB = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_W_CD = 3'd5;

   // dot product stages, then divider prep, bit stages and output stage
   localparam int DOT_LAT = 3;
   localparam int DIV_LAT = DATA_W + 2;

   typedef logic [3:0][DATA_W-1:0] vec4_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clip;
      logic              zero;
   } div_res_type;

endpackage

FILE: hdl/perspective_point_projection_core.sv
// Top level of the perspective point projection core.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | point_x, point_y, point_z, point_w
//  rsp     | out       | rsp_valid/stall   | screen_x, screen_y, at_infinity, clipped
//  csr     | in        | csr_valid/ready   | csr_index, csr_data
//
// One request per cycle unless a stalled result holds the pipeline; each result passes
// through 3 dot product stages and a 34-stage divider that retires one quotient bit per bit stage.
// Synchronous reset clears the valid chain and the coefficient registers; while reset
// is high no request and no register write is taken.
// A stalled result holds the whole pipeline; req_stall follows it in the same cycle.
module perspective_point_projection_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ppp_pkg::DATA_W-1:0]  req_point_x,
   input  logic signed [ppp_pkg::DATA_W-1:0]  req_point_y,
   input  logic signed [ppp_pkg::DATA_W-1:0]  req_point_z,
   input  logic signed [ppp_pkg::DATA_W-1:0]  req_point_w,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ppp_pkg::DATA_W-1:0]  rsp_screen_x,
   output logic signed [ppp_pkg::DATA_W-1:0]  rsp_screen_y,
   output logic                               rsp_at_infinity,
   output logic                               rsp_clipped,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppp_pkg::CSR_W-1:0]          csr_data
);
   localparam int LAT = ppp_pkg::DOT_LAT + ppp_pkg::DIV_LAT;
   localparam int AW  = 66 - FRAC_BITS;

   logic [ppp_pkg::CSR_W-1:0] row_ff [6];
   logic [LAT-1:0]            vld_ff;
   logic                      en;

   assign csr_ready = !reset;
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = reset || !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            row_ff[k] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ppp_pkg::CSR_ROW_X_AB: row_ff[0] <= csr_data;
            ppp_pkg::CSR_ROW_X_CD: row_ff[1] <= csr_data;
            ppp_pkg::CSR_ROW_Y_AB: row_ff[2] <= csr_data;
            ppp_pkg::CSR_ROW_Y_CD: row_ff[3] <= csr_data;
            ppp_pkg::CSR_ROW_W_AB: row_ff[4] <= csr_data;
            ppp_pkg::CSR_ROW_W_CD: row_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   ppp_pkg::vec4_type pt;
   ppp_pkg::vec4_type coef_x, coef_y, coef_w;

   assign pt     = {req_point_w, req_point_z, req_point_y, req_point_x};
   assign coef_x = {row_ff[1][63:32], row_ff[1][31:0], row_ff[0][63:32], row_ff[0][31:0]};
   assign coef_y = {row_ff[3][63:32], row_ff[3][31:0], row_ff[2][63:32], row_ff[2][31:0]};
   assign coef_w = {row_ff[5][63:32], row_ff[5][31:0], row_ff[4][63:32], row_ff[4][31:0]};

   logic signed [AW-1:0] acc_x, acc_y, acc_w;

   ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
      .clock(clock), .en(en), .coef(coef_x), .pt(pt), .acc(acc_x));
   ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
      .clock(clock), .en(en), .coef(coef_y), .pt(pt), .acc(acc_y));
   ppp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
      .clock(clock), .en(en), .coef(coef_w), .pt(pt), .acc(acc_w));

   ppp_pkg::div_res_type res_x, res_y;

   ppp_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .en(en), .num(acc_x), .den(acc_w), .res(res_x));
   ppp_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .en(en), .num(acc_y), .den(acc_w), .res(res_y));

   assign rsp_valid       = vld_ff[LAT-1];
   assign rsp_screen_x    = res_x.value;
   assign rsp_screen_y    = res_y.value;
   assign rsp_at_infinity = res_x.zero && res_y.zero;
   assign rsp_clipped     = res_x.clip || res_y.clip;

endmodule

FILE: hdl/ppp_dot.sv
// Pipelined four-term fixed-point dot product of one matrix row with the point.
module ppp_dot #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  ppp_pkg::vec4_type             coef,
   input  ppp_pkg::vec4_type             pt,
   output logic signed [65-FRAC_BITS:0]  acc
);
   localparam int PW = 2 * ppp_pkg::DATA_W;
   localparam int SW = PW - FRAC_BITS;
   localparam int AW = SW + 2;

   logic signed [PW-1:0]  prod_ff [4];
   logic signed [SW:0]    pair_ff [2];
   logic signed [SW:0]    pair_in [2];
   logic signed [AW-1:0]  acc_ff;
   logic signed [SW-1:0]  flr [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         flr[k] = SW'(prod_ff[k] >>> FRAC_BITS);
      end
      pair_in[0] = (SW+1)'(flr[0]) + (SW+1)'(flr[1]);
      pair_in[1] = (SW+1)'(flr[2]) + (SW+1)'(flr[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed(coef[k]) * $signed(pt[k]);
         end
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
         acc_ff <= AW'(pair_ff[0]) + AW'(pair_ff[1]);
      end
   end

   assign acc = acc_ff;

endmodule

FILE: hdl/ppp_divider.sv
// Bit-per-stage pipelined signed fixed-point divider with saturation.
module ppp_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [65-FRAC_BITS:0]  num,
   input  logic signed [65-FRAC_BITS:0]  den,
   output ppp_pkg::div_res_type          res
);
   localparam int DW = ppp_pkg::DATA_W;
   localparam int AW = 66 - FRAC_BITS;

   logic [AW:0]    r_ff   [DW+1];
   logic [AW-1:0]  d_ff   [DW+1];
   logic [DW-1:0]  lo_ff  [DW+1];
   logic [DW-1:0]  q_ff   [DW+1];
   logic           neg_ff [DW+1];
   logic           ovf_ff [DW+1];
   logic           zero_ff [DW+1];
   ppp_pkg::div_res_type res_ff;

   logic [AW-1:0]  un;
   logic [AW-1:0]  ud;
   logic [AW-1:0]  hi;

   always_comb begin
      un = num[AW-1] ? (~num + AW'(1)) : num;
      ud = den[AW-1] ? (~den + AW'(1)) : den;
      hi = un >> (DW - FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= {1'b0, hi};
         d_ff[0]    <= ud;
         lo_ff[0]   <= {un[DW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[AW-1] ^ den[AW-1];
         ovf_ff[0]  <= hi >= ud;
         zero_ff[0] <= den == '0;
      end
   end

   for (genvar g = 0; g < DW; g++) begin : g_bit
      logic [AW:0] rs;
      logic        ge;
      always_comb begin
         rs = {r_ff[g][AW-1:0], lo_ff[g][DW-1]};
         ge = rs >= {1'b0, d_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[g+1]    <= ge ? (rs - {1'b0, d_ff[g]}) : rs;
            q_ff[g+1]    <= {q_ff[g][DW-2:0], ge};
            lo_ff[g+1]   <= {lo_ff[g][DW-2:0], 1'b0};
            d_ff[g+1]    <= d_ff[g];
            neg_ff[g+1]  <= neg_ff[g];
            ovf_ff[g+1]  <= ovf_ff[g];
            zero_ff[g+1] <= zero_ff[g];
         end
      end
   end

   logic [DW-1:0]        limit;
   logic                 clip;
   logic [DW-1:0]        mag;
   ppp_pkg::div_res_type res_in;

   always_comb begin
      limit = neg_ff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      clip  = ovf_ff[DW] || (q_ff[DW] > limit);
      mag   = clip ? limit : q_ff[DW];
      res_in.zero  = zero_ff[DW];
      res_in.clip  = clip && !zero_ff[DW];
      res_in.value = zero_ff[DW] ? '0 : (neg_ff[DW] ? (~mag + DW'(1)) : mag);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

FILE: hdl/ppp_checker.sv
// Port-level assertions for the perspective point projection core, with bind.
module ppp_port_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ppp_pkg::DATA_W-1:0]        rsp_screen_x,
   input logic [ppp_pkg::DATA_W-1:0]        rsp_screen_y,
   input logic                              rsp_at_infinity,
   input logic                              rsp_clipped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y))
      else $error("stalled result changed");

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_infinity |-> rsp_screen_x == '0 && rsp_screen_y == '0
         && !rsp_clipped)
      else $error("point at infinity with nonzero result");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind perspective_point_projection_core ppp_port_props u_ppp_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_screen_x(rsp_screen_x),
   .rsp_screen_y(rsp_screen_y),
   .rsp_at_infinity(rsp_at_infinity),
   .rsp_clipped(rsp_clipped)
);

FILE: tb/ppp_checker.sv
// Checker for the perspective point projection core: predicts results and compares them.
module ppp_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [ppp_pkg::DATA_W-1:0] req_point_x,
   input  logic signed [ppp_pkg::DATA_W-1:0] req_point_y,
   input  logic signed [ppp_pkg::DATA_W-1:0] req_point_z,
   input  logic signed [ppp_pkg::DATA_W-1:0] req_point_w,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [ppp_pkg::DATA_W-1:0] rsp_screen_x,
   input  logic signed [ppp_pkg::DATA_W-1:0] rsp_screen_y,
   input  logic                              rsp_at_infinity,
   input  logic                              rsp_clipped,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppp_pkg::CSR_W-1:0]         csr_data,
   output int                                error_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic        inf;
      logic        clip;
   } pixel_type;

   logic [ppp_pkg::CSR_W-1:0] coef [6];
   pixel_type                 pixel_queue [$];

   function automatic logic signed [127:0] floor_product(logic signed [31:0] c,
                                                        logic signed [31:0] p);
      logic signed [127:0] prod;
      prod = 128'(c) * 128'(p);
      return prod >>> FRAC_BITS;
   endfunction

   function automatic logic signed [127:0] row_sum(logic [63:0] ab, logic [63:0] cd,
                                                  logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz,
                                                  logic signed [31:0] pw);
      return floor_product(ab[31:0], px) + floor_product(ab[63:32], py)
           + floor_product(cd[31:0], pz) + floor_product(cd[63:32], pw);
   endfunction

   function automatic logic [31:0] scaled_quotient(logic signed [127:0] n,
                                                   logic signed [127:0] d,
                                                   inout logic clip);
      logic         neg;
      logic [127:0] un, ud, q, lim;
      neg = (n < 0) != (d < 0);
      un  = n < 0 ? -n : n;
      ud  = d < 0 ? -d : d;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      q   = (un << FRAC_BITS) / ud;
      if (q > lim) begin
         clip = 1'b1;
         q    = lim;
      end
      if (neg) q = -q;
      return q[31:0];
   endfunction

   function automatic pixel_type project(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz, logic signed [31:0] pw);
      pixel_type           r;
      logic signed [127:0] ax, ay, aw;
      logic                clip;
      clip = 1'b0;
      r    = '0;
      ax   = row_sum(coef[ppp_pkg::CSR_ROW_X_AB], coef[ppp_pkg::CSR_ROW_X_CD],
                     px, py, pz, pw);
      ay   = row_sum(coef[ppp_pkg::CSR_ROW_Y_AB], coef[ppp_pkg::CSR_ROW_Y_CD],
                     px, py, pz, pw);
      aw   = row_sum(coef[ppp_pkg::CSR_ROW_W_AB], coef[ppp_pkg::CSR_ROW_W_CD],
                     px, py, pz, pw);
      if (aw == 0) begin
         r.inf = 1'b1;
         return r;
      end
      r.sx   = scaled_quotient(ax, aw, clip);
      r.sy   = scaled_quotient(ay, aw, clip);
      r.clip = clip;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         for (int i = 0; i < 6; i++) coef[i] <= '0;
         pixel_queue.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (req_valid && !req_stall)
            pixel_queue = {pixel_queue,
                           project(req_point_x, req_point_y, req_point_z, req_point_w)};
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected result", '0, '0);
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_screen_x !== want.sx) report_mismatch("screen_x", rsp_screen_x, want.sx);
               if (rsp_screen_y !== want.sy) report_mismatch("screen_y", rsp_screen_y, want.sy);
               if (rsp_at_infinity !== want.inf)
                  report_mismatch("at_infinity", 32'(rsp_at_infinity), 32'(want.inf));
               if (rsp_clipped !== want.clip)
                  report_mismatch("clipped", 32'(rsp_clipped), 32'(want.clip));
            end
         end
         pending_count = pixel_queue.size();
         if (csr_valid && csr_ready && csr_index < 6) coef[csr_index] <= csr_data;
      end
   end
endmodule

FILE: tb/tb.sv
// Top of the perspective point projection testbench: stimulus and verdict.
module tb;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0, req_stall;
   logic signed [31:0] req_point_x = 0, req_point_y = 0, req_point_z = 0, req_point_w = 0;
   logic              rsp_valid, rsp_stall = 0;
   logic signed [31:0] rsp_screen_x, rsp_screen_y;
   logic              rsp_at_infinity, rsp_clipped;
   logic              csr_valid = 0, csr_ready;
   logic [ppp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ppp_pkg::CSR_W-1:0]  csr_data = '0;
   int                error_count, pending_count;
   int                send_idle_pct = 15, recv_idle_pct = 71;
   logic              hold_off = 0;
   longint            cycle_count = 0;

   localparam int ONE = 32'h0001_0000;
   // indexes past the last row register; writes there are dropped
   localparam logic [ppp_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ppp_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   perspective_point_projection_core dut (.*);

   ppp_checker checker_inst (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

   task automatic write_csr(logic [ppp_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_rows(logic [63:0] xab, xcd, yab, ycd, wab, wcd);
      write_csr(ppp_pkg::CSR_ROW_X_AB, xab);
      write_csr(ppp_pkg::CSR_ROW_X_CD, xcd);
      write_csr(ppp_pkg::CSR_ROW_Y_AB, yab);
      write_csr(ppp_pkg::CSR_ROW_Y_CD, ycd);
      write_csr(ppp_pkg::CSR_ROW_W_AB, wab);
      write_csr(ppp_pkg::CSR_ROW_W_CD, wcd);
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, {$urandom, $urandom});
      csr_valid <= 0;
   endtask

   task automatic send_point(logic [31:0] x, y, z, w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid   <= 1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_point_w <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(2000)) - 1000;
         2: return $signed(32'($urandom_range(64)) << 16) - (32 << 16);
         default: return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      endcase
   endfunction

   function automatic logic [63:0] rand_pair();
      return {rand_coord(), rand_coord()};
   endfunction

   initial begin
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: identity-like camera
      load_rows({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {ONE, 32'd0});
      send_point(ONE, ONE, ONE, ONE);
      send_point(32'h7fff_ffff, 32'h8000_0000, 0, ONE);
      send_point(0, 0, 0, 0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
      send_point(ONE * 5, -ONE * 3, ONE, -ONE);
      send_point(ONE, 2, 3, 32'h8000_0000);
      send_point(32'hffff_ffff, 32'hffff_ffff, 0, 32'h7fff_ffff);
      drain();
      // extreme and unit-magnitude coefficients
      load_rows('1, {32'h8000_0000, 32'h7fff_ffff}, 64'h7fff_ffff_7fff_ffff,
                64'h8000_0000_8000_0000, '1, 64'h0000_0001_ffff_ffff);
      for (int i = 0; i < 12; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                               rand_coord());
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      drain();
      // long receiver hold-off while requests keep coming
      load_rows(rand_pair(), rand_pair(), rand_pair(), rand_pair(), rand_pair(), rand_pair());
      fork
         begin
            hold_off = 1;
            repeat (150) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 80; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                                  rand_coord());
      join
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 71;
            recv_idle_pct = 15;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int s = 0; s < 3; s++) begin
            if (s == 0)
               load_rows({$urandom_range(1) ? rand_coord() : 32'd0, ONE}, rand_pair(),
                         {ONE, 32'd0}, rand_pair(), 64'd0, {ONE, 32'd0});
            else
               load_rows(rand_pair(), rand_pair(), rand_pair(), rand_pair(),
                         rand_pair(), rand_pair());
            for (int i = 0; i < 100; i++) begin
               if (s == 0 && $urandom_range(3) != 0)
                  send_point(rand_coord(), rand_coord(), rand_coord(),
                             $urandom_range(1) ? ONE : 0);
               else
                  send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            drain();
         end
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

FILE: filelist.f
hdl/ppp_pkg.sv
hdl/ppp_dot.sv
hdl/ppp_divider.sv
hdl/perspective_point_projection_core.sv
hdl/ppp_checker.sv
tb/ppp_checker.sv
tb/tb.sv
